/* rtl/core/bf5_pkg.sv */
// Shared types and constants of the 5x5 box filter.
package bf5_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR_MODE   = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic                  RST_COLOR_MODE   = 1'b1;

  localparam int DIM_MIN = 5;
  localparam int WIN     = 5;   // window edge
  localparam int LINES   = 4;   // full lines held in the line store

  localparam int CHAN_W      = 8;
  localparam int COL_SUM_W   = 11;  // five channel values
  localparam int WIN_SUM_W   = 13;  // twenty-five channel values
  // floor(s / 25) == (s * 5243) >> 17 for every window sum s.
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = WIN_SUM_W + RECIP_W;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pixel_t;

  // Lane k holds the pixel k+1 lines back (on read) or k lines back (on write).
  typedef pixel_t [LINES-1:0] lanes_t;
  // Index is lines back, 0 is the newest row.
  typedef pixel_t [WIN-1:0] column_t;
  // Index is items back, 0 is the newest column.
  typedef column_t [WIN-1:0] window_t;

  // Per-item control that travels with the pixel through the pipeline.
  typedef struct packed {
    logic           res;     // this item releases a result
    logic           last;    // that result is the final pixel of the frame
    logic [WIN-1:0] row_ok;  // window row inside the image, by lines back
    logic [WIN-1:0] col_ok;  // window column inside the image, by items back
  } tag_t;

endpackage

/* rtl/core/box_filter_5x5_stream.sv */
// 5x5 mean filter over a raster-order RGB or gray pixel stream.
// One pixel is taken every clock; the only thing that holds the input back
// is a result waiting in the output register while the consumer stalls.
// Pixels pass an input register, a line store (one RAM of MAX_WIDTH words,
// each holding four line-delayed pixels), the 5x5 window registers, a
// column-sum stage, a window-sum stage and the divide-by-25 multiply into
// the result register. The result for pixel n comes with input item n+2W+2;
// after the W*H pixels of a frame send 2W+2 padding items, whose data is
// ignored. Writing any register restarts the frame; the store needs no
// clearing after reset. frame_last marks the result for the final pixel.
module box_filter_5x5_stream #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  logic [bf5_pkg::CHAN_W-1:0]        red,
  input  logic [bf5_pkg::CHAN_W-1:0]        green,
  input  logic [bf5_pkg::CHAN_W-1:0]        blue,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [bf5_pkg::CHAN_W-1:0]        mean_red,
  output logic [bf5_pkg::CHAN_W-1:0]        mean_green,
  output logic [bf5_pkg::CHAN_W-1:0]        mean_blue,
  output logic                              frame_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             adv;
  logic             accept;
  logic             color_mode;
  logic [AW-1:0]    rd_addr;
  bf5_pkg::tag_t    tag;
  bf5_pkg::tag_t    win_tag;
  bf5_pkg::window_t win;
  bf5_pkg::pixel_t  pix;

  // The whole pipeline moves unless a result is held by the consumer.
  assign adv       = !res_valid || !res_stall;
  assign pix_stall = !adv;
  assign accept    = pix_valid && adv;

  assign pix.r = red;
  assign pix.g = green;
  assign pix.b = blue;

  bf5_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .color_mode (color_mode),
    .rd_addr    (rd_addr),
    .tag        (tag)
  );

  bf5_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .accept  (accept),
    .pix     (pix),
    .tag_in  (tag),
    .rd_addr (rd_addr),
    .win     (win),
    .win_tag (win_tag)
  );

  bf5_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .color_mode (color_mode),
    .win        (win),
    .win_tag    (win_tag),
    .res_valid  (res_valid),
    .mean_red   (mean_red),
    .mean_green (mean_green),
    .mean_blue  (mean_blue),
    .frame_last (frame_last)
  );

endmodule

/* rtl/core/bf5_ram.sv */
// Generic simple dual-port RAM with registered read data.
module bf5_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bf5_ctrl.sv */
// Configuration registers, frame position counters and per-item window masks.
module bf5_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bf5_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bf5_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               color_mode,
  output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
  output bf5_pkg::tag_t                      tag
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW_W = (WW > bf5_pkg::CFG_DATA_W) ? WW : bf5_pkg::CFG_DATA_W;
  localparam int CMPW_H = (HW > bf5_pkg::CFG_DATA_W) ? HW : bf5_pkg::CFG_DATA_W;
  localparam int XE     = WW + 1;
  localparam int YE     = HW + 1;
  localparam int LAGW   = $clog2(2 * MAX_WIDTH + 3);

  logic [bf5_pkg::CFG_DATA_W-1:0] image_width;
  logic [bf5_pkg::CFG_DATA_W-1:0] image_height;
  logic [AW-1:0]                  ptr;
  logic [AW-1:0]                  col;
  logic [YW-1:0]                  row;
  logic [LAGW-1:0]                fill;

  logic [CMPW_W-1:0] width_cfg;
  logic [CMPW_H-1:0] height_cfg;
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [LAGW-1:0]   lag;
  logic              col_end;
  logic              row_end;
  logic              ptr_end;
  logic              cfg_hit;

  assign cfg_ready = 1'b1;
  assign rd_addr   = ptr;

  // Registers outside the legal range saturate to it.
  assign width_cfg  = CMPW_W'(image_width);
  assign height_cfg = CMPW_H'(image_height);

  always_comb begin
    if (width_cfg < CMPW_W'(bf5_pkg::DIM_MIN)) begin
      w_eff = WW'(bf5_pkg::DIM_MIN);
    end else if (width_cfg > CMPW_W'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg);
    end
    if (height_cfg < CMPW_H'(bf5_pkg::DIM_MIN)) begin
      h_eff = HW'(bf5_pkg::DIM_MIN);
    end else if (height_cfg > CMPW_H'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_cfg);
    end
  end

  // The first 2W+2 items of a frame only fill the line store.
  assign lag     = (LAGW'(w_eff) << 1) + LAGW'(2);
  assign col_end = XE'(col) == XE'(w_eff) - XE'(1);
  assign row_end = YE'(row) == YE'(h_eff) - YE'(1);
  assign ptr_end = XE'(ptr) == XE'(w_eff) - XE'(1);

  always_comb begin
    tag.res       = (fill == lag);
    tag.last      = tag.res && row_end && col_end;
    tag.row_ok[0] = YE'(row) + YE'(2) < YE'(h_eff);
    tag.row_ok[1] = YE'(row) + YE'(1) < YE'(h_eff);
    tag.row_ok[2] = 1'b1;
    tag.row_ok[3] = YE'(row) >= YE'(1);
    tag.row_ok[4] = YE'(row) >= YE'(2);
    tag.col_ok[0] = XE'(col) + XE'(2) < XE'(w_eff);
    tag.col_ok[1] = XE'(col) + XE'(1) < XE'(w_eff);
    tag.col_ok[2] = 1'b1;
    tag.col_ok[3] = XE'(col) >= XE'(1);
    tag.col_ok[4] = XE'(col) >= XE'(2);
  end

  always_comb begin
    case (cfg_index)
      bf5_pkg::REG_IMAGE_WIDTH:  cfg_hit = cfg_valid;
      bf5_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
      bf5_pkg::REG_COLOR_MODE:   cfg_hit = cfg_valid;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bf5_pkg::RST_IMAGE_WIDTH;
      image_height <= bf5_pkg::RST_IMAGE_HEIGHT;
      color_mode   <= bf5_pkg::RST_COLOR_MODE;
      ptr          <= '0;
      col          <= '0;
      row          <= '0;
      fill         <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        bf5_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bf5_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        bf5_pkg::REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: ;
      endcase
      // A register write starts a fresh frame.
      ptr  <= '0;
      col  <= '0;
      row  <= '0;
      fill <= '0;
    end else if (accept) begin
      if (tag.last) begin
        ptr  <= '0;
        col  <= '0;
        row  <= '0;
        fill <= '0;
      end else begin
        ptr <= ptr_end ? '0 : ptr + AW'(1);
        if (!tag.res) begin
          fill <= fill + LAGW'(1);
        end else if (col_end) begin
          col <= '0;
          row <= row + YW'(1);
        end else begin
          col <= col + AW'(1);
        end
      end
    end
  end

endmodule

/* rtl/core/bf5_window.sv */
// Input register, four-line store and the 5x5 window shift registers.
module bf5_window #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          accept,
  input  bf5_pkg::pixel_t               pix,
  input  bf5_pkg::tag_t                 tag_in,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output bf5_pkg::window_t              win,
  output bf5_pkg::tag_t                 win_tag
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             s1_valid;
  bf5_pkg::pixel_t  s1_pix;
  bf5_pkg::tag_t    s1_tag;
  logic [AW-1:0]    s1_addr;
  logic [$bits(bf5_pkg::lanes_t)-1:0] rd_data;
  bf5_pkg::lanes_t  rd_lanes;
  bf5_pkg::lanes_t  wr_lanes;
  bf5_pkg::column_t new_col;
  bf5_pkg::tag_t    win_tag_next;
  logic             shift;

  assign shift    = s1_valid && adv;
  assign rd_lanes = bf5_pkg::lanes_t'(rd_data);

  // Each store word holds one column of four line-delayed pixels; the word
  // written back drops the oldest one and pushes the current pixel in.
  always_comb begin
    wr_lanes[0] = s1_pix;
    new_col[0]  = s1_pix;
    for (int i = 1; i < bf5_pkg::LINES; i++) begin
      wr_lanes[i] = rd_lanes[i-1];
    end
    for (int i = 1; i < bf5_pkg::WIN; i++) begin
      new_col[i] = rd_lanes[i-1];
    end
  end

  always_comb begin
    win_tag_next     = s1_tag;
    win_tag_next.res = s1_valid && s1_tag.res;
  end

  bf5_ram #(
    .WIDTH ($bits(bf5_pkg::lanes_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (shift),
    .waddr (s1_addr),
    .wdata (wr_lanes),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_tag   <= '0;
      win_tag  <= '0;
    end else if (adv) begin
      s1_valid <= accept;
      s1_tag   <= tag_in;
      win_tag  <= win_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pix;
      s1_addr <= rd_addr;
    end
    if (shift) begin
      win[0] <= new_col;
      for (int j = 1; j < bf5_pkg::WIN; j++) begin
        win[j] <= win[j-1];
      end
    end
  end

endmodule

/* rtl/core/bf5_sum.sv */
// Masked window sums, division by 25 and the result register.
module bf5_sum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         color_mode,
  input  bf5_pkg::window_t             win,
  input  bf5_pkg::tag_t                win_tag,
  output logic                         res_valid,
  output logic [bf5_pkg::CHAN_W-1:0]   mean_red,
  output logic [bf5_pkg::CHAN_W-1:0]   mean_green,
  output logic [bf5_pkg::CHAN_W-1:0]   mean_blue,
  output logic                         frame_last
);

  localparam int CSW = bf5_pkg::COL_SUM_W;
  localparam int TSW = bf5_pkg::WIN_SUM_W;
  localparam int PW  = bf5_pkg::PROD_W;

  logic [CSW-1:0] cs_r [bf5_pkg::WIN];
  logic [CSW-1:0] cs_g [bf5_pkg::WIN];
  logic [CSW-1:0] cs_b [bf5_pkg::WIN];
  logic [CSW-1:0] c_r  [bf5_pkg::WIN];
  logic [CSW-1:0] c_g  [bf5_pkg::WIN];
  logic [CSW-1:0] c_b  [bf5_pkg::WIN];
  logic           c_valid;
  logic           c_last;

  logic [TSW-1:0] ts_r, ts_g, ts_b;
  logic [TSW-1:0] d_r, d_g, d_b;
  logic           d_valid;
  logic           d_last;

  logic [PW-1:0]  p_r, p_g, p_b;

  // Pixels outside the image count as zero.
  always_comb begin
    for (int j = 0; j < bf5_pkg::WIN; j++) begin
      cs_r[j] = '0;
      cs_g[j] = '0;
      cs_b[j] = '0;
      for (int k = 0; k < bf5_pkg::WIN; k++) begin
        if (win_tag.row_ok[k] && win_tag.col_ok[j]) begin
          cs_r[j] = cs_r[j] + CSW'(win[j][k].r);
          cs_g[j] = cs_g[j] + CSW'(win[j][k].g);
          cs_b[j] = cs_b[j] + CSW'(win[j][k].b);
        end
      end
    end
  end

  always_comb begin
    ts_r = '0;
    ts_g = '0;
    ts_b = '0;
    for (int j = 0; j < bf5_pkg::WIN; j++) begin
      ts_r = ts_r + TSW'(c_r[j]);
      ts_g = ts_g + TSW'(c_g[j]);
      ts_b = ts_b + TSW'(c_b[j]);
    end
  end

  assign p_r = PW'(d_r) * PW'(bf5_pkg::RECIP);
  assign p_g = PW'(d_g) * PW'(bf5_pkg::RECIP);
  assign p_b = PW'(d_b) * PW'(bf5_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      c_valid   <= win_tag.res;
      d_valid   <= c_valid;
      res_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r    <= cs_r;
      c_g    <= cs_g;
      c_b    <= cs_b;
      c_last <= win_tag.last;
      d_r    <= ts_r;
      d_g    <= ts_g;
      d_b    <= ts_b;
      d_last <= c_last;
      mean_red   <= color_mode ? p_r[bf5_pkg::RECIP_SHIFT +: bf5_pkg::CHAN_W] : '0;
      mean_green <= p_g[bf5_pkg::RECIP_SHIFT +: bf5_pkg::CHAN_W];
      mean_blue  <= color_mode ? p_b[bf5_pkg::RECIP_SHIFT +: bf5_pkg::CHAN_W] : '0;
      frame_last <= d_last;
    end
  end

endmodule

/* rtl/core/bf5_checker.sv */
// Port-level checks of the box filter, bound to its top level.
module bf5_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              pix_valid,
  input logic                              pix_stall,
  input logic                              res_valid,
  input logic                              res_stall,
  input logic [bf5_pkg::CHAN_W-1:0]        mean_red,
  input logic [bf5_pkg::CHAN_W-1:0]        mean_green,
  input logic [bf5_pkg::CHAN_W-1:0]        mean_blue,
  input logic                              frame_last
);

  // No result survives a reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // The input is only held back by a result the consumer refuses.
  a_stall_cause: assert property (@(posedge clk)
    pix_stall |-> (res_valid && res_stall))
    else $error("input stalled without a stalled result");

  // A refused result stays and keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(mean_red) &&
      $stable(mean_green) && $stable(mean_blue) && $stable(frame_last)))
    else $error("stalled result changed");

endmodule

bind box_filter_5x5_stream bf5_checker u_bf5_checker (.*);

/* test/box_mean_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the 5x5 window means of the pixel stream and compares each result.
module box_mean_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pix_valid,
  input  logic                              pix_stall,
  input  logic [bf5_pkg::CHAN_W-1:0]        red,
  input  logic [bf5_pkg::CHAN_W-1:0]        green,
  input  logic [bf5_pkg::CHAN_W-1:0]        blue,
  input  logic                              res_valid,
  input  logic                              res_stall,
  input  logic [bf5_pkg::CHAN_W-1:0]        mean_red,
  input  logic [bf5_pkg::CHAN_W-1:0]        mean_green,
  input  logic [bf5_pkg::CHAN_W-1:0]        mean_blue,
  input  logic                              frame_last,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                mean_errors,
  output int                                means_waiting
);

  localparam int HIST_DEPTH = 4 * MAX_WIDTH + 8;

  typedef struct packed {
    logic [bf5_pkg::CHAN_W-1:0] r, g, b;
    logic                       last;
  } mean_t;

  bf5_pkg::pixel_t                pixel_hist [HIST_DEPTH];
  mean_t                          expected_means [$];
  logic [bf5_pkg::CFG_DATA_W-1:0] width_reg;
  logic [bf5_pkg::CFG_DATA_W-1:0] height_reg;
  logic                           color_reg;
  int                             col_pos;
  int                             row_pos;
  int                             frame_items;
  int                             hist_pos;

  function automatic int clamp_dim(input logic [bf5_pkg::CFG_DATA_W-1:0] raw, input int hi);
    if (raw < bf5_pkg::DIM_MIN) return bf5_pkg::DIM_MIN;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  function automatic void restart_frame();
    col_pos     = 0;
    row_pos     = 0;
    frame_items = 0;
    hist_pos    = 0;
  endfunction

  // Stores the pixel and, once 2W+2 items of the frame are in, produces the
  // mean for the pixel two lines and two columns back.
  function automatic void filter_pixel(input bf5_pkg::pixel_t px);
    int              w;
    int              h;
    int              rr;
    int              cc;
    int              back_dist;
    int              sum_r;
    int              sum_g;
    int              sum_b;
    bf5_pkg::pixel_t v;
    mean_t           m;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    pixel_hist[hist_pos] = px;
    if (frame_items >= 2 * w + 2) begin
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          rr = row_pos + dr;
          cc = col_pos + dc;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
            back_dist = (2 - dr) * w + (2 - dc);
            v = pixel_hist[(hist_pos + HIST_DEPTH - back_dist) % HIST_DEPTH];
            sum_r += v.r;
            sum_g += v.g;
            sum_b += v.b;
          end
        end
      end
      m.r    = color_reg ? 8'(sum_r / 25) : 8'd0;
      m.g    = 8'(sum_g / 25);
      m.b    = color_reg ? 8'(sum_b / 25) : 8'd0;
      m.last = (row_pos == h - 1) && (col_pos == w - 1);
      expected_means.push_back(m);
      if (m.last) begin
        restart_frame();
        return;
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    frame_items++;
    hist_pos = (hist_pos + 1) % HIST_DEPTH;
  endfunction

  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    if (rst) begin
      width_reg  = bf5_pkg::RST_IMAGE_WIDTH;
      height_reg = bf5_pkg::RST_IMAGE_HEIGHT;
      color_reg  = bf5_pkg::RST_COLOR_MODE;
      restart_frame();
      expected_means.delete();
      mean_errors = 0;
    end else begin
      // A result can never come from an item accepted at the same edge, so
      // results are matched before this edge's item is predicted.
      if (res_valid && !res_stall) begin
        got = {mean_red, mean_green, mean_blue, frame_last};
        if (expected_means.size() == 0) begin
          mean_errors++;
          $display("%0t: result with none expected: r=%0d g=%0d b=%0d last=%0b",
                   $time, got.r, got.g, got.b, got.last);
        end else begin
          want = expected_means.pop_front();
          if (got !== want) begin
            mean_errors++;
            $display("%0t: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                     $time, want.r, want.g, want.b, want.last,
                     got.r, got.g, got.b, got.last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bf5_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_data;
            restart_frame();
          end
          bf5_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data;
            restart_frame();
          end
          bf5_pkg::REG_COLOR_MODE: begin
            color_reg = cfg_data[0];
            restart_frame();
          end
          default: begin
          end
        endcase
      end
      if (pix_valid && !pix_stall)
        filter_pixel({red, green, blue});
    end
    means_waiting <= expected_means.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Top of the 5x5 box filter testbench: clock, reset, pixel and register stimulus, verdict.
module tb_top;

  typedef logic [bf5_pkg::CHAN_W-1:0]     level_t;
  typedef logic [bf5_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  // Index 3 decodes to no register; a write there must leave the frame alone.
  localparam logic [bf5_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 400;

  logic                              clk        = 1'b0;
  logic                              rst        = 1'b1;
  logic                              pix_valid  = 1'b0;
  logic [bf5_pkg::CHAN_W-1:0]        red        = '0;
  logic [bf5_pkg::CHAN_W-1:0]        green      = '0;
  logic [bf5_pkg::CHAN_W-1:0]        blue       = '0;
  logic                              res_stall  = 1'b0;
  logic                              cfg_valid  = 1'b0;
  logic [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index  = '0;
  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                              pix_stall;
  logic                              res_valid;
  logic [bf5_pkg::CHAN_W-1:0]        mean_red;
  logic [bf5_pkg::CHAN_W-1:0]        mean_green;
  logic [bf5_pkg::CHAN_W-1:0]        mean_blue;
  logic                              frame_last;
  logic                              cfg_ready;
  int                                mean_errors;
  int                                means_waiting;

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit long_hold = 1'b0;
  bit mid_frame = 1'b0;
  int items_sent = 0;
  int cur_w;
  int cur_h;

  box_filter_5x5_stream #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (
    .clk, .rst, .pix_valid, .pix_stall, .red, .green, .blue,
    .res_valid, .res_stall, .mean_red, .mean_green, .mean_blue, .frame_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  box_mean_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) mean_chk (
    .clk, .rst, .pix_valid, .pix_stall, .red, .green, .blue,
    .res_valid, .res_stall, .mean_red, .mean_green, .mean_blue, .frame_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mean_errors, .means_waiting
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("box_filter_5x5_stream test failed");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !held) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  function automatic level_t pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return level_t'($urandom);
    endcase
  endfunction

  // Items in one whole frame, padding included.
  function automatic int frame_len();
    return cur_w * cur_h + 2 * cur_w + 2;
  endfunction

  task automatic send_pixel(input bf5_pkg::pixel_t px);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red       <= px.r;
    green     <= px.g;
    blue      <= px.b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_pixel({pick_level(), pick_level(), pick_level()});
  endtask

  // Waits until every expected result is out and the pipeline has drained.
  task automatic settle();
    pix_valid <= 1'b0;
    do @(posedge clk); while (means_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bf5_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bf5_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // raw_* is what gets written, w and h the sizes the block will use.
  task automatic configure(input logic [bf5_pkg::CFG_DATA_W-1:0] raw_w,
                           input logic [bf5_pkg::CFG_DATA_W-1:0] raw_h,
                           input logic mode, input int w, input int h);
    write_reg(bf5_pkg::REG_IMAGE_WIDTH, raw_w);
    write_reg(bf5_pkg::REG_IMAGE_HEIGHT, raw_h);
    write_reg(bf5_pkg::REG_COLOR_MODE, {11'($urandom), mode});
    cur_w     = w;
    cur_h     = h;
    mid_frame = 1'b0;
  endtask

  initial begin
    int                               w;
    int                               h;
    int                               frames;
    int                               items_goal;
    logic [bf5_pkg::CFG_DATA_W-1:0]   raw_w;
    logic [bf5_pkg::CFG_DATA_W-1:0]   raw_h;
    bit                               hold_done;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes: a few results past the first lag show the reset values.
    cur_w = int'(bf5_pkg::RST_IMAGE_WIDTH);
    cur_h = int'(bf5_pkg::RST_IMAGE_HEIGHT);
    send_pixels(2 * cur_w + 2 + 10);
    settle();

    // Smallest frame, saturated and dark.
    configure(12'd5, 12'd5, 1'b1, 5, 5);
    repeat (frame_len()) send_pixel('1);
    repeat (frame_len()) send_pixel('0);
    settle();

    // Sizes below the minimum, gray mode, and a write to the unused index
    // in the middle of a frame.
    configure(12'd0, 12'd4, 1'b0, 5, 5);
    send_pixels(10);
    settle();
    write_reg(REG_SPARE, cfg_word_t'($urandom));
    send_pixels(frame_len() - 10);
    settle();

    // A frame dropped before any result is due.
    configure(12'd9, 12'd6, 1'b1, 9, 6);
    send_pixels(10);
    settle();

    items_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < items_goal) begin
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(5, 12);
      h = $urandom_range(5, 8);
      raw_w = (w == 5 && $urandom_range(0, 1) == 1) ?
              cfg_word_t'($urandom_range(0, 4)) : cfg_word_t'(w);
      raw_h = (h == 5 && $urandom_range(0, 1) == 1) ?
              cfg_word_t'($urandom_range(0, 4)) : cfg_word_t'(h);
      if (mid_frame || $urandom_range(0, 3) != 0)
        configure(raw_w, raw_h, 1'($urandom_range(0, 1)), w, h);
      if (!hold_done) begin
        // The sender keeps offering items so that the block backs up.
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      frames = $urandom_range(1, 3);
      repeat (frames) send_pixels(frame_len());
      mid_frame = $urandom_range(0, 4) == 0;
      if (mid_frame)
        send_pixels($urandom_range(1, frame_len() - 1));
      settle();
    end

    src_idle  = 1'b0;
    sink_idle = 1'b0;
    configure(12'd7, 12'd6, 1'b1, 7, 6);
    repeat (2) send_pixels(frame_len());
    settle();

    if (mean_errors == 0 && means_waiting == 0)
      $display("box_filter_5x5_stream test passed");
    else
      $display("box_filter_5x5_stream test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bf5_pkg.sv
rtl/core/bf5_ram.sv
rtl/core/bf5_ctrl.sv
rtl/core/bf5_window.sv
rtl/core/bf5_sum.sv
rtl/core/box_filter_5x5_stream.sv
rtl/core/bf5_checker.sv
test/box_mean_checker.sv
test/tb_top.sv
